// File: rtl/core/dwsm_pkg.sv
// shared types and constants of the whole-string dfa matcher
package dwsm_pkg;

  localparam int STATE_BITS    = 8;
  localparam int SYM_BITS      = 8;
  localparam int TAG_BITS      = 16;
  localparam int STATE_COUNT   = 1 << STATE_BITS;
  localparam int SIU_BITS      = STATE_BITS + 1;
  localparam int TADDR_BITS    = STATE_BITS + SYM_BITS;
  localparam int TRANS_DEPTH   = 1 << TADDR_BITS;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;

  typedef enum logic [1:0] {
    OP_LOAD_TRANS = 2'd0,
    OP_LOAD_ACC   = 2'd1,
    OP_CHAR       = 2'd2,
    OP_END        = 2'd3
  } op_t;

  // register index, taken from paddr[2]
  localparam logic REG_START_STATE   = 1'b0;
  localparam logic REG_STATES_IN_USE = 1'b1;

  typedef struct packed {
    logic                  vld;
    logic [STATE_BITS-1:0] tgt;
  } trans_ent_t;

  typedef struct packed {
    logic                acc;
    logic [TAG_BITS-1:0] tag;
  } acc_ent_t;

  typedef struct packed {
    logic                  wr;
    logic [TADDR_BITS-1:0] waddr;
    trans_ent_t            wdata;
    logic                  rd;
    logic [TADDR_BITS-1:0] raddr;
  } trans_req_t;

  typedef struct packed {
    logic                  wr;
    logic [STATE_BITS-1:0] waddr;
    acc_ent_t              wdata;
    logic                  rd;
    logic [STATE_BITS-1:0] raddr;
  } acc_req_t;

endpackage

// File: rtl/core/dwsm_trans_mem.sv
// transition table memory with a clearing sweep after reset
module dwsm_trans_mem import dwsm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  trans_req_t req,
  output trans_ent_t rdata,
  output logic       busy
);

  trans_ent_t            mem [TRANS_DEPTH];
  trans_ent_t            rdata_r;
  logic [TADDR_BITS-1:0] clr_idx_r, clr_idx_nxt;
  logic                  clearing_r, clearing_nxt;

  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_idx_nxt  = clr_idx_r + 1'b1;
      clearing_nxt = (clr_idx_r != '1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clearing_r;

endmodule

// File: rtl/core/dwsm_acc_mem.sv
// accept table memory, one valid bit per state
module dwsm_acc_mem import dwsm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  acc_req_t req,
  output acc_ent_t rdata
);

  acc_ent_t               mem [STATE_COUNT];
  acc_ent_t               rdata_r;
  logic                   rvld_r;
  logic [STATE_COUNT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= mem[req.raddr];
      rvld_r  <= vld_r[req.raddr];
    end
  end

  // a never-written state reads as not accepting, tag zero
  assign rdata.acc = rvld_r & rdata_r.acc;
  assign rdata.tag = rvld_r ? rdata_r.tag : '0;

endmodule

// File: rtl/core/dfa_whole_string_match_unit.sv
// top level of the table-driven whole-string dfa matcher
// Input channel (in_valid/in_ready) carries one request per item: load
// transition, load accept entry, character, or end of string. Only an end
// request produces a result on the output channel (out_valid/out_ready):
// matched and the accepting state's tag.
// Character requests run at one per cycle while in_ready is high: the
// transition memory is read at {state, byte} and its registered data is
// forwarded straight into the next address. Loads write on acceptance.
// An end request reads the accept memory; its result passes that memory's
// read register, then the output register; further requests can be taken.
// When the output register is full and out_ready is low, one further end
// result waits inside; in_ready then drops until the output drains.
// After reset the transition memory is cleared one entry a cycle, all 65536
// entries, with in_ready low; configuration writes on the APB port are taken
// throughout. start_state and states_in_use reset to zero.
module dfa_whole_string_match_unit import dwsm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_opcode,
  input  logic [STATE_BITS-1:0]    in_from_state,
  input  logic [SYM_BITS-1:0]      in_symbol,
  input  logic [STATE_BITS-1:0]    in_target_state,
  input  logic                     in_entry_valid,
  input  logic [TAG_BITS-1:0]      in_accept_tag,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_matched,
  output logic [TAG_BITS-1:0]      out_result_tag,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [STATE_BITS-1:0] start_r;
  logic [SIU_BITS-1:0]   siu_r;

  logic [STATE_BITS-1:0] cur_r, cur_nxt;
  logic                  failed_r, failed_nxt;
  logic                  in_str_r, in_str_nxt;
  logic                  tpend_r, tpend_nxt;
  logic                  epend_r, epend_nxt;
  logic                  eok_r, eok_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_matched_r, out_matched_nxt;
  logic [TAG_BITS-1:0]   out_tag_r, out_tag_nxt;

  trans_req_t            treq;
  trans_ent_t            t_rd;
  logic                  t_busy;
  acc_req_t              areq;
  acc_ent_t              a_rd;

  logic [STATE_BITS-1:0] cur_res, cur_eff;
  logic                  fail_res, st_ok, out_free, in_fire, ehit;
  logic [TAG_BITS-1:0]   etag;
  op_t                   op;

  dwsm_trans_mem u_trans (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (treq),
    .rdata (t_rd),
    .busy  (t_busy)
  );

  dwsm_acc_mem u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rdata (a_rd)
  );

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      siu_r   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_START_STATE:   start_r <= pwdata[STATE_BITS-1:0];
        REG_STATES_IN_USE: siu_r   <= pwdata[SIU_BITS-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STATES_IN_USE: prdata = {{(CFG_DATA_BITS-SIU_BITS){1'b0}}, siu_r};
      default:           prdata = {{(CFG_DATA_BITS-STATE_BITS){1'b0}}, start_r};
    endcase
  end

  // resolve the lookup issued last cycle
  assign cur_res  = (tpend_r && t_rd.vld) ? t_rd.tgt : cur_r;
  assign fail_res = failed_r | (tpend_r & ~t_rd.vld);
  assign cur_eff  = in_str_r ? cur_res : start_r;
  assign st_ok    = ({1'b0, cur_eff} < siu_r);

  assign out_free = ~out_valid_r | out_ready;
  assign in_ready = ~t_busy & (~epend_r | out_free);
  assign in_fire  = in_valid & in_ready;
  assign op       = op_t'(in_opcode);

  assign ehit = eok_r & a_rd.acc;
  assign etag = ehit ? a_rd.tag : '0;

  always_comb begin
    cur_nxt         = cur_res;
    failed_nxt      = fail_res;
    in_str_nxt      = in_str_r;
    tpend_nxt       = 1'b0;
    epend_nxt       = epend_r & ~out_free;
    eok_nxt         = eok_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_matched_nxt = out_matched_r;
    out_tag_nxt     = out_tag_r;
    treq            = '0;
    areq            = '0;

    if (epend_r && out_free) begin
      out_valid_nxt   = 1'b1;
      out_matched_nxt = ehit;
      out_tag_nxt     = etag;
    end

    if (in_fire) begin
      unique case (op)
        OP_LOAD_TRANS: begin
          treq.wr        = 1'b1;
          treq.waddr     = {in_from_state, in_symbol};
          treq.wdata.vld = in_entry_valid;
          treq.wdata.tgt = in_entry_valid ? in_target_state : '0;
        end
        OP_LOAD_ACC: begin
          areq.wr        = 1'b1;
          areq.waddr     = in_from_state;
          areq.wdata.acc = in_entry_valid;
          areq.wdata.tag = in_entry_valid ? in_accept_tag : '0;
        end
        OP_CHAR: begin
          in_str_nxt = 1'b1;
          cur_nxt    = cur_eff;
          // characters after a failure are dropped until the end request
          if (!fail_res) begin
            if (!st_ok) begin
              failed_nxt = 1'b1;
            end else begin
              treq.rd    = 1'b1;
              treq.raddr = {cur_eff, in_symbol};
              tpend_nxt  = 1'b1;
            end
          end
        end
        OP_END: begin
          areq.rd    = 1'b1;
          areq.raddr = cur_eff;
          epend_nxt  = 1'b1;
          eok_nxt    = ~fail_res & st_ok;
          cur_nxt    = start_r;
          failed_nxt = 1'b0;
          in_str_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      failed_r    <= 1'b0;
      in_str_r    <= 1'b0;
      tpend_r     <= 1'b0;
      epend_r     <= 1'b0;
      eok_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      failed_r    <= failed_nxt;
      in_str_r    <= in_str_nxt;
      tpend_r     <= tpend_nxt;
      epend_r     <= epend_nxt;
      eok_r       <= eok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r <= out_matched_nxt;
    out_tag_r     <= out_tag_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_matched    = out_matched_r;
  assign out_result_tag = out_tag_r;

endmodule
